### src/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

    localparam int AddrWidth     = 16;
    localparam int DataWidth     = 8;
    localparam int KindWidth     = 3;
    localparam int RomAddrWidth  = 21;
    localparam int RamAddrWidth  = 15;
    localparam int RomBankWidth  = 7;
    localparam int RamSelWidth   = 4;
    localparam int CountWidth    = 8;
    localparam int CfgIndexWidth = 2;

    // access kinds
    localparam logic [KindWidth-1:0] KIND_ROM    = 3'd0;
    localparam logic [KindWidth-1:0] KIND_RAM_RD = 3'd1;
    localparam logic [KindWidth-1:0] KIND_RAM_WR = 3'd2;
    localparam logic [KindWidth-1:0] KIND_FIXED  = 3'd3;
    localparam logic [KindWidth-1:0] KIND_NONE   = 3'd4;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_ROM_BANK_COUNT = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_HAS_RAM        = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_TIMER_PRESENT  = 2'd2;

    // bus access modes
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // address regions by address[15:13]
    localparam logic [2:0] REGION_RAM_EN   = 3'b000;
    localparam logic [2:0] REGION_ROM_BANK = 3'b001;
    localparam logic [2:0] REGION_RAM_SEL  = 3'b010;
    localparam logic [2:0] REGION_LATCH    = 3'b011;
    localparam logic [2:0] REGION_CART_RAM = 3'b101;

    localparam logic [3:0] RAM_EN_KEY    = 4'hA;
    localparam logic [DataWidth-1:0] OPEN_BUS  = 8'hFF;
    localparam logic [DataWidth-1:0] CLOCK_VAL = 8'h00;
    localparam logic [RamSelWidth-1:0] CLOCK_SEL_LO = 4'h8;
    localparam logic [RamSelWidth-1:0] CLOCK_SEL_HI = 4'hC;
    localparam logic [RamSelWidth-1:0] RAM_SEL_LIMIT = 4'h4;

    typedef struct packed {
        logic                 mode;
        logic [AddrWidth-1:0] address;
        logic [DataWidth-1:0] write_data;
    } acc_t;

    typedef struct packed {
        logic [KindWidth-1:0]    access_kind;
        logic [RomAddrWidth-1:0] rom_address;
        logic [RamAddrWidth-1:0] ram_address;
        logic [DataWidth-1:0]    ram_write_data;
        logic [DataWidth-1:0]    fixed_value;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### src/cbm_rem_unit.sv
`default_nettype none

module cbm_rem_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              step,
    input  wire logic [cbm_pkg::RomBankWidth-1:0]  dividend,
    input  wire logic [cbm_pkg::CountWidth-1:0]    divisor,
    output logic      [cbm_pkg::RomBankWidth-1:0]  remainder,
    output logic                                   last
);

    localparam int CntWidth = $clog2(cbm_pkg::RomBankWidth);
    localparam logic [CntWidth-1:0] CntInit = CntWidth'(cbm_pkg::RomBankWidth - 1);

    logic [cbm_pkg::CountWidth-1:0]   rem_reg, rem_next;
    logic [cbm_pkg::RomBankWidth-1:0] dvd_reg, dvd_next;
    logic [CntWidth-1:0]              cnt_reg, cnt_next;
    logic [cbm_pkg::CountWidth:0]     shifted;

    // one restoring step per cycle while step is high, quotient bits discarded
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[cbm_pkg::RomBankWidth-1]};
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            cnt_next = CntInit;
        end
        else if (step)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = cbm_pkg::CountWidth'(shifted - {1'b0, divisor});
            end
            else
            begin
                rem_next = cbm_pkg::CountWidth'(shifted);
            end
            dvd_next = {dvd_reg[cbm_pkg::RomBankWidth-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    // remainder never exceeds the 7-bit dividend
    assign remainder = rem_reg[cbm_pkg::RomBankWidth-1:0];
    assign last      = (cnt_reg == '0);

endmodule

`default_nettype wire

### src/cbm_ctrl.sv
`default_nettype none

module cbm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             acc_valid,
    output logic                  acc_ready,
    input  wire cbm_pkg::status_t status,
    output cbm_pkg::cmd_t         cmd
);

    cbm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        acc_ready  = 1'b0;
        case (state_reg)
            cbm_pkg::ST_IDLE:
            begin
                acc_ready = 1'b1;
                if (acc_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = cbm_pkg::ST_EXEC;
                end
            end
            cbm_pkg::ST_EXEC:
            begin
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = cbm_pkg::ST_DIV;
                end
                else if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = cbm_pkg::ST_IDLE;
                end
            end
            cbm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = cbm_pkg::ST_DONE;
                end
            end
            cbm_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = cbm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/cbm_datapath.sv
`default_nettype none

module cbm_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire cbm_pkg::cmd_t                       cmd,
    output cbm_pkg::status_t                         status,
    input  wire cbm_pkg::acc_t                       acc_payload,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output cbm_pkg::res_t                            res_payload,
    input  wire logic                                cfg_valid,
    input  wire logic [cbm_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  wire logic [cbm_pkg::DataWidth-1:0]       cfg_data
);

    // configuration
    logic [cbm_pkg::CountWidth-1:0] bank_count_reg, bank_count_next;
    logic has_ram_reg, has_ram_next;
    logic timer_reg, timer_next;

    // mapper state
    logic ram_en_reg, ram_en_next;
    logic [cbm_pkg::RomBankWidth-1:0] rom_bank_reg, rom_bank_next;
    logic [cbm_pkg::RamSelWidth-1:0]  ram_sel_reg, ram_sel_next;

    cbm_pkg::acc_t acc_reg;
    cbm_pkg::res_t res_reg, res_calc;
    logic res_valid_reg, res_valid_next;

    logic [2:0] region;
    logic [cbm_pkg::RomBankWidth-1:0] bank_wr_val;
    logic [cbm_pkg::RomBankWidth-1:0] dividend;
    logic [cbm_pkg::RomBankWidth-1:0] remainder;
    logic div_last;
    logic count_zero;
    logic is_write;

    assign region     = acc_reg.address[15:13];
    assign is_write   = (acc_reg.mode == cbm_pkg::MODE_WRITE);
    assign count_zero = (bank_count_reg == '0);

    // written bank: low 7 bits, zero promoted to one
    assign bank_wr_val = (acc_reg.write_data[cbm_pkg::RomBankWidth-1:0] == '0)
                         ? cbm_pkg::RomBankWidth'(1)
                         : acc_reg.write_data[cbm_pkg::RomBankWidth-1:0];
    assign dividend = (region == cbm_pkg::REGION_ROM_BANK) ? bank_wr_val : rom_bank_reg;

    cbm_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .step      (cmd.div_step),
        .dividend  (dividend),
        .divisor   (bank_count_reg),
        .remainder (remainder),
        .last      (div_last)
    );

    always_comb
    begin
        status.need_div = is_write && !count_zero
                          && (region == cbm_pkg::REGION_ROM_BANK
                              || region == cbm_pkg::REGION_RAM_SEL);
        status.div_last = div_last;
        status.out_free = !res_valid_reg || res_ready;
    end

    // result decode
    always_comb
    begin
        res_calc = '0;
        res_calc.access_kind = cbm_pkg::KIND_NONE;
        if (!is_write)
        begin
            if (acc_reg.address[15] == 1'b0)
            begin
                res_calc.access_kind = cbm_pkg::KIND_ROM;
                res_calc.rom_address = {acc_reg.address[14] ? rom_bank_reg
                                                             : cbm_pkg::RomBankWidth'(0),
                                        acc_reg.address[13:0]};
            end
            else
            begin
                res_calc.access_kind = cbm_pkg::KIND_FIXED;
                res_calc.fixed_value = cbm_pkg::OPEN_BUS;
                if (region == cbm_pkg::REGION_CART_RAM && ram_en_reg)
                begin
                    if (ram_sel_reg < cbm_pkg::RAM_SEL_LIMIT)
                    begin
                        if (has_ram_reg)
                        begin
                            res_calc.access_kind = cbm_pkg::KIND_RAM_RD;
                            res_calc.fixed_value = '0;
                            res_calc.ram_address = {ram_sel_reg[1:0],
                                                    acc_reg.address[12:0]};
                        end
                    end
                    else if (ram_sel_reg >= cbm_pkg::CLOCK_SEL_LO
                             && ram_sel_reg <= cbm_pkg::CLOCK_SEL_HI && timer_reg)
                    begin
                        res_calc.fixed_value = cbm_pkg::CLOCK_VAL;
                    end
                end
            end
        end
        else if (region == cbm_pkg::REGION_CART_RAM && ram_en_reg && has_ram_reg
                 && ram_sel_reg < cbm_pkg::RAM_SEL_LIMIT)
        begin
            res_calc.access_kind    = cbm_pkg::KIND_RAM_WR;
            res_calc.ram_address    = {ram_sel_reg[1:0], acc_reg.address[12:0]};
            res_calc.ram_write_data = acc_reg.write_data;
        end
    end

    // state updates on commit
    always_comb
    begin
        ram_en_next   = ram_en_reg;
        rom_bank_next = rom_bank_reg;
        ram_sel_next  = ram_sel_reg;
        if (cmd.commit && is_write)
        begin
            case (region)
                cbm_pkg::REGION_RAM_EN:
                begin
                    ram_en_next = (acc_reg.write_data[3:0] == cbm_pkg::RAM_EN_KEY);
                end
                cbm_pkg::REGION_ROM_BANK:
                begin
                    rom_bank_next = count_zero ? bank_wr_val : remainder;
                end
                cbm_pkg::REGION_RAM_SEL:
                begin
                    ram_sel_next  = acc_reg.write_data[cbm_pkg::RamSelWidth-1:0];
                    rom_bank_next = count_zero ? rom_bank_reg : remainder;
                end
                default:
                begin
                    ram_en_next = ram_en_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        bank_count_next = bank_count_reg;
        has_ram_next    = has_ram_reg;
        timer_next      = timer_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                cbm_pkg::CFG_ROM_BANK_COUNT: bank_count_next = cfg_data;
                cbm_pkg::CFG_HAS_RAM:        has_ram_next    = cfg_data[0];
                cbm_pkg::CFG_TIMER_PRESENT:  timer_next      = cfg_data[0];
                default:                     timer_next      = timer_reg;
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_count_reg <= cbm_pkg::CountWidth'(2);
            has_ram_reg    <= 1'b0;
            timer_reg      <= 1'b0;
            ram_en_reg     <= 1'b1;
            rom_bank_reg   <= cbm_pkg::RomBankWidth'(1);
            ram_sel_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            bank_count_reg <= bank_count_next;
            has_ram_reg    <= has_ram_next;
            timer_reg      <= timer_next;
            ram_en_reg     <= ram_en_next;
            rom_bank_reg   <= rom_bank_next;
            ram_sel_reg    <= ram_sel_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            acc_reg <= acc_payload;
        end
        if (cmd.commit)
        begin
            res_reg <= res_calc;
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_payload = res_reg;

endmodule

`default_nettype wire

### src/cartridge_bank_mapper.sv
// Cartridge bank mapper: each bus beat on the acc channel (read or write, 16-bit address,
// data byte) yields exactly one result beat on the res channel naming the memory access it
// causes (rom read, cart ram read or write, fixed read value, or none). A read is captured
// on acceptance, then decoded and committed to the result register once it is free. Writes
// to the rom bank or ram bank select range pass through a reduction while rom_bank_count is
// non-zero, because the stored bank is reduced modulo the bank count by a restoring remainder
// unit that retires one dividend bit per cycle; with a count of zero no reduction is made. A
// new beat is taken as soon as the previous one is committed, even while its result still
// waits in the output register. Configuration writes are taken at any time and must only be
// issued while the block is idle.
`default_nettype none

module cartridge_bank_mapper (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // bus access channel
    input  wire logic                               acc_valid,
    output logic                                    acc_ready,
    input  wire cbm_pkg::acc_t                      acc_payload,
    // result channel
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output cbm_pkg::res_t                           res_payload,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cbm_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  wire logic [cbm_pkg::DataWidth-1:0]      cfg_data
);

    cbm_pkg::cmd_t    cmd;
    cbm_pkg::status_t status;

    // configuration registers are plain flops, always writable
    assign cfg_ready = 1'b1;

    // sequencer: capture, decode, optional bank reduction, commit
    cbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // mapper registers, decode, remainder unit and result register
    cbm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .acc_payload (acc_payload),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_payload (res_payload),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

endmodule

`default_nettype wire

### tb/tb_cartridge_bank_mapper.sv
`timescale 1ns / 1ps

class mapper_scoreboard;
    // configuration copy
    bit [cbm_pkg::CountWidth-1:0]   bank_count;
    bit                             ram_fitted;
    bit                             clock_fitted;
    // mapper state copy
    bit                             ram_on;
    bit [cbm_pkg::RomBankWidth-1:0] rom_bank;
    bit [cbm_pkg::RamSelWidth-1:0]  ram_sel;
    cbm_pkg::res_t                  expected_accesses[$];
    int                             mismatches;

    function new();
        bank_count   = 8'd2;
        ram_fitted   = 1'b0;
        clock_fitted = 1'b0;
        ram_on       = 1'b1;
        rom_bank     = 7'd1;
        ram_sel      = '0;
        mismatches   = 0;
    endfunction

    function void set_register(logic [cbm_pkg::CfgIndexWidth-1:0] index,
                               logic [cbm_pkg::DataWidth-1:0] value);
        case (index)
            cbm_pkg::CFG_ROM_BANK_COUNT: bank_count   = value;
            cbm_pkg::CFG_HAS_RAM:        ram_fitted   = value[0];
            cbm_pkg::CFG_TIMER_PRESENT:  clock_fitted = value[0];
            default:                     ;
        endcase
    endfunction

    // a count of zero stands for 256 banks, so the bank is kept
    function bit [cbm_pkg::RomBankWidth-1:0] fold_bank(bit [cbm_pkg::RomBankWidth-1:0] bank);
        if (bank_count == 0)
            return bank;
        return cbm_pkg::RomBankWidth'(bank % bank_count);
    endfunction

    function cbm_pkg::res_t map_access(cbm_pkg::acc_t a);
        cbm_pkg::res_t                  r;
        int unsigned                    ram_off;
        bit [cbm_pkg::RomBankWidth-1:0] bank;
        r             = '0;
        r.access_kind = cbm_pkg::KIND_NONE;
        ram_off       = (a.address & 16'h1FFF) + ram_sel * 8192;
        if (a.mode == cbm_pkg::MODE_READ)
        begin
            case (a.address[15:13])
                cbm_pkg::REGION_RAM_EN, cbm_pkg::REGION_ROM_BANK:
                begin
                    r.access_kind = cbm_pkg::KIND_ROM;
                    r.rom_address = cbm_pkg::RomAddrWidth'(a.address[13:0]);
                end
                cbm_pkg::REGION_RAM_SEL, cbm_pkg::REGION_LATCH:
                begin
                    r.access_kind = cbm_pkg::KIND_ROM;
                    r.rom_address = cbm_pkg::RomAddrWidth'(a.address[13:0]
                                                           + rom_bank * 16384);
                end
                cbm_pkg::REGION_CART_RAM:
                begin
                    r.access_kind = cbm_pkg::KIND_FIXED;
                    r.fixed_value = cbm_pkg::OPEN_BUS;
                    if (ram_on)
                    begin
                        if (ram_sel < cbm_pkg::RAM_SEL_LIMIT)
                        begin
                            if (ram_fitted)
                            begin
                                r.access_kind = cbm_pkg::KIND_RAM_RD;
                                r.fixed_value = '0;
                                r.ram_address = ram_off[cbm_pkg::RamAddrWidth-1:0];
                            end
                        end
                        else if (ram_sel >= cbm_pkg::CLOCK_SEL_LO
                                 && ram_sel <= cbm_pkg::CLOCK_SEL_HI && clock_fitted)
                            r.fixed_value = cbm_pkg::CLOCK_VAL;
                    end
                end
                default:
                begin
                    r.access_kind = cbm_pkg::KIND_FIXED;
                    r.fixed_value = cbm_pkg::OPEN_BUS;
                end
            endcase
        end
        else
        begin
            case (a.address[15:13])
                cbm_pkg::REGION_RAM_EN:
                    ram_on = (a.write_data[3:0] == cbm_pkg::RAM_EN_KEY);
                cbm_pkg::REGION_ROM_BANK:
                begin
                    bank = a.write_data[6:0];
                    if (bank == 0)
                        bank = 7'd1;
                    rom_bank = fold_bank(bank);
                end
                cbm_pkg::REGION_RAM_SEL:
                begin
                    ram_sel  = a.write_data[3:0];
                    rom_bank = fold_bank(rom_bank);
                end
                cbm_pkg::REGION_CART_RAM:
                    if (ram_on && ram_fitted && ram_sel < cbm_pkg::RAM_SEL_LIMIT)
                    begin
                        r.access_kind    = cbm_pkg::KIND_RAM_WR;
                        r.ram_address    = ram_off[cbm_pkg::RamAddrWidth-1:0];
                        r.ram_write_data = a.write_data;
                    end
                default:
                    ;
            endcase
        end
        return r;
    endfunction

    function void note_access(cbm_pkg::acc_t a);
        expected_accesses.push_back(map_access(a));
    endfunction

    function int pending();
        return expected_accesses.size();
    endfunction

    task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    task check_access(cbm_pkg::res_t got);
        cbm_pkg::res_t want;
        if (expected_accesses.size() == 0)
        begin
            report_mismatch("beat with nothing outstanding", '0, 32'(got.access_kind));
            return;
        end
        want = expected_accesses.pop_front();
        if (got.access_kind !== want.access_kind)
            report_mismatch("access_kind", 32'(want.access_kind), 32'(got.access_kind));
        if (got.rom_address !== want.rom_address)
            report_mismatch("rom_address", 32'(want.rom_address), 32'(got.rom_address));
        if (got.ram_address !== want.ram_address)
            report_mismatch("ram_address", 32'(want.ram_address), 32'(got.ram_address));
        if (got.ram_write_data !== want.ram_write_data)
            report_mismatch("ram_write_data", 32'(want.ram_write_data),
                            32'(got.ram_write_data));
        if (got.fixed_value !== want.fixed_value)
            report_mismatch("fixed_value", 32'(want.fixed_value), 32'(got.fixed_value));
    endtask
endclass

module tb_cartridge_bank_mapper;
    localparam int ClkPeriod     = 20;
    localparam int ResetCycles   = 9;
    localparam int MaxGap        = 10;
    localparam int PhaseCount    = 8;
    localparam int RandomPhase   = 6;
    localparam int ItemsPerPhase = 47;
    // long receiver stall part way through, so the block backs up into its input
    localparam int HoldAtBeat    = 200;
    localparam int HoldCycles    = 300;
    // worst path through the block is a bank write with the remainder unit
    localparam int SettleCycles  = 24;
    localparam int CycleLimit    = 200000;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              acc_valid;
    logic                              acc_ready;
    cbm_pkg::acc_t                     acc_payload;
    logic                              res_valid;
    logic                              res_ready;
    cbm_pkg::res_t                     res_payload;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [cbm_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [cbm_pkg::DataWidth-1:0]     cfg_data;

    mapper_scoreboard sb = new();

    int tx_burst    = 0;
    int rx_burst    = 0;
    int rx_count    = 0;
    int cycle_count = 0;

    // per-phase cartridge settings, the extremes of the bank count among them
    logic [cbm_pkg::CountWidth-1:0] phase_count [PhaseCount] =
        '{8'd128, 8'd2, 8'd0, 8'd255, 8'd1, 8'd64, 8'd3, 8'd128};
    logic phase_ram   [PhaseCount] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    logic phase_clock [PhaseCount] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    always #(ClkPeriod / 2) clk = ~clk;

    cartridge_bank_mapper u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc_valid   (acc_valid),
        .acc_ready   (acc_ready),
        .acc_payload (acc_payload),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_payload (res_payload),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // idle gap for the next beat; now and then a stretch of back-to-back beats
    function automatic int draw_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            burst = $urandom_range(10, 30);
        return $urandom_range(0, MaxGap);
    endfunction

    function automatic cbm_pkg::acc_t bus_beat(logic mode,
                                               logic [cbm_pkg::AddrWidth-1:0] address,
                                               logic [cbm_pkg::DataWidth-1:0] data);
        cbm_pkg::acc_t a;
        a.mode       = mode;
        a.address    = address;
        a.write_data = data;
        return a;
    endfunction

    // random bus access, weighted towards the mapped windows and the control writes
    // so that ram gets enabled, banks move and clock selects come up often
    function automatic cbm_pkg::acc_t random_access();
        cbm_pkg::acc_t a;
        int            pick;
        pick         = $urandom_range(0, 99);
        a.mode       = 1'($urandom_range(0, 1));
        a.address    = 16'($urandom());
        a.write_data = 8'($urandom());
        if (pick < 28)
        begin
            // rom reads, fixed and switched bank
            a.mode       = cbm_pkg::MODE_READ;
            a.address[15] = 1'b0;
        end
        else if (pick < 50)
            a.address[15:13] = cbm_pkg::REGION_CART_RAM;
        else if (pick < 60)
        begin
            a.mode           = cbm_pkg::MODE_WRITE;
            a.address[15:13] = cbm_pkg::REGION_ROM_BANK;
            if ($urandom_range(0, 7) == 0)
                a.write_data[6:0] = '0;
        end
        else if (pick < 70)
        begin
            a.mode           = cbm_pkg::MODE_WRITE;
            a.address[15:13] = cbm_pkg::REGION_RAM_SEL;
            case ($urandom_range(0, 3))
                0, 1:    a.write_data[3:0] = 4'($urandom_range(0, 3));
                2:       a.write_data[3:0] = 4'($urandom_range(8, 12));
                default: ;
            endcase
        end
        else if (pick < 78)
        begin
            a.mode           = cbm_pkg::MODE_WRITE;
            a.address[15:13] = cbm_pkg::REGION_RAM_EN;
            if ($urandom_range(0, 3) != 0)
                a.write_data[3:0] = cbm_pkg::RAM_EN_KEY;
        end
        else if (pick < 83)
        begin
            a.mode           = cbm_pkg::MODE_WRITE;
            a.address[15:13] = cbm_pkg::REGION_LATCH;
        end
        return a;
    endfunction

    // offer one beat; valid stays up across back-to-back beats
    task automatic send_access(cbm_pkg::acc_t a);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0)
        begin
            acc_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        acc_valid   <= 1'b1;
        acc_payload <= a;
        @(posedge clk);
        while (!acc_ready)
            @(posedge clk);
        sb.note_access(a);
    endtask

    task automatic write_register(logic [cbm_pkg::CfgIndexWidth-1:0] index,
                                  logic [cbm_pkg::DataWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(index, value);
    endtask

    task automatic apply_config(logic [cbm_pkg::CountWidth-1:0] count, logic ram,
                                logic clock);
        write_register(cbm_pkg::CFG_ROM_BANK_COUNT, count);
        write_register(cbm_pkg::CFG_HAS_RAM, cbm_pkg::DataWidth'(ram));
        write_register(cbm_pkg::CFG_TIMER_PRESENT, cbm_pkg::DataWidth'(clock));
        cfg_valid <= 1'b0;
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic drain();
        acc_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls, plus one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(rx_burst);
            if (rx_count == HoldAtBeat)
                gap = HoldCycles;
            if (gap > 0)
            begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            sb.check_access(res_payload);
            rx_count++;
        end
    end

    initial
    begin
        cbm_pkg::acc_t directed_beats[$];
        logic [cbm_pkg::CountWidth-1:0] count;
        logic ram;
        logic clock;

        rst_n       <= 1'b0;
        acc_valid   <= 1'b0;
        acc_payload <= '0;
        res_ready   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opener: window edges, bank zero made one, bank at its widest,
        // ram write and read, clock selects, unused select, disabled ram, latch, unmapped
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'h0000, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'h3FFF, 8'hFF));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'h4000, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'h2000, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'h3FFF, 8'hFF));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'h7FFF, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'h4000, 8'h03));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'hA000, 8'h5A));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'hBFFF, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'h5FFF, 8'h08));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'hA000, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'h4000, 8'h0C));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'hBFFF, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'h4000, 8'h0D));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'hA000, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'h4000, 8'hF0));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'h0000, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'hA000, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'hBFFF, 8'h33));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'h1FFF, 8'hFA));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'h6000, 8'h01));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'h8000, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_READ,  16'hFFFF, 8'h00));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'hC000, 8'hAA));
        directed_beats.push_back(bus_beat(cbm_pkg::MODE_WRITE, 16'hFFFF, 8'h55));

        for (int p = 0; p < PhaseCount; p++)
        begin
            // registers only change with the block idle
            drain();
            count = phase_count[p];
            ram   = phase_ram[p];
            clock = phase_clock[p];
            if (p == RandomPhase)
            begin
                count = cbm_pkg::CountWidth'($urandom_range(2, 128));
                ram   = 1'($urandom_range(0, 1));
                clock = 1'($urandom_range(0, 1));
            end
            apply_config(count, ram, clock);
            if (p == 0)
                foreach (directed_beats[i])
                    send_access(directed_beats[i]);
            for (int i = 0; i < ItemsPerPhase; i++)
                send_access(random_access());
        end

        drain();
        repeat (SettleCycles) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
